[rtl/sstg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept square tone generator package
// Shared widths, register index codes and helper functions for the tone
// generator and its checker.
// ----------------------------------------------------------------------------
package sstg_pkg;

   // Width of the phase accumulator.
   localparam int PHASE_BITS = 32;
   // Width of the blip sample counter.
   localparam int LENGTH_BITS = 16;

   // Field and register widths.
   localparam int CSR_DATA_BITS   = 32;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int INC_BITS        = 31;
   localparam int SWEEP_BITS      = 32;
   localparam int DECAY_BITS      = 16;
   localparam int VOLUME_BITS     = 15;
   localparam int BLIP_LEN_BITS   = 16;
   localparam int ENV_BITS        = 17;
   localparam int SAMPLE_BITS     = 16;

   // Envelope value for 1.0 in Q16.
   localparam logic [ENV_BITS-1:0] ENV_ONE = 17'h10000;
   // Largest sample magnitude.
   localparam logic [SAMPLE_BITS-1:0] MAG_MAX = 16'h7FFF;
   // Largest count the sample counter can hold.
   localparam logic [31:0] LENGTH_MAX = (32'd1 << LENGTH_BITS) - 32'd1;

   // Reset values of the configuration registers.
   localparam logic [DECAY_BITS-1:0]  DECAY_RESET  = 16'hFFFF;
   localparam logic [VOLUME_BITS-1:0] VOLUME_RESET = 15'h7FFF;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_START_INCREMENT = 3'd0,
      CSR_SWEEP_STEP      = 3'd1,
      CSR_DECAY_FACTOR    = 3'd2,
      CSR_VOLUME          = 3'd3,
      CSR_BLIP_LENGTH     = 3'd4
   } csr_index_type;

   // Clamp a programmed blip length to the range of the sample counter.
   function automatic logic [LENGTH_BITS-1:0] sat_length(
      input logic [BLIP_LEN_BITS-1:0] len
   );
      logic [31:0] wide;
      wide = 32'(len);
      if (wide > LENGTH_MAX) begin
         return '1;
      end
      return wide[LENGTH_BITS-1:0];
   endfunction

   // Add the signed sweep step to the phase step, saturating to 0..2^31-1.
   function automatic logic [INC_BITS-1:0] sweep_inc(
      input logic [INC_BITS-1:0]   inc,
      input logic [SWEEP_BITS-1:0] step
   );
      logic [SWEEP_BITS:0] sum;
      sum = {2'b00, inc} + {step[SWEEP_BITS-1], step};
      if (sum[SWEEP_BITS]) begin
         return '0;
      end else if (sum[INC_BITS]) begin
         return '1;
      end
      return sum[INC_BITS-1:0];
   endfunction

endpackage

[rtl/swept_square_tone_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept square tone generator
// Produces one audio sample per request: a square wave whose phase step
// sweeps linearly, shaped by a geometric decay envelope and a volume gain.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  req       in         req_valid/req_stall  req_trigger
//  rsp       out        rsp_valid/rsp_stall  rsp_sample, rsp_active, rsp_last
//  csr       in         csr_write_enable     csr_index, csr_data
//
// The tone state updates and the result is registered at the edge that
// accepts a request, and a new request may follow in the very next cycle
// unless the request side stalls. The path is set by the two small envelope
// multipliers. Reset clears the tone state and the result valid flag and sets
// the registers to their default values. The request side stalls only while a
// result is held in the output register and the result side stalls.
//
module swept_square_tone_generator (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel.
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_trigger,
   // Result channel.
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [sstg_pkg::SAMPLE_BITS-1:0] rsp_sample,
   output logic                                   rsp_active,
   output logic                                   rsp_last,
   // Configuration port.
   input  logic                                   csr_write_enable,
   input  logic [sstg_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sstg_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   // Configuration registers.
   logic [sstg_pkg::INC_BITS-1:0]      start_inc_ff;
   logic [sstg_pkg::SWEEP_BITS-1:0]    sweep_step_ff;
   logic [sstg_pkg::DECAY_BITS-1:0]    decay_ff;
   logic [sstg_pkg::VOLUME_BITS-1:0]   volume_ff;
   logic [sstg_pkg::BLIP_LEN_BITS-1:0] blip_len_ff;

   // Tone state.
   logic [sstg_pkg::PHASE_BITS-1:0]  phase_ff,   phase_in;
   logic [sstg_pkg::INC_BITS-1:0]    inc_ff,     inc_in;
   logic [sstg_pkg::ENV_BITS-1:0]    env_ff,     env_in;
   logic [sstg_pkg::LENGTH_BITS-1:0] left_ff,    left_in;

   // Result register.
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [sstg_pkg::SAMPLE_BITS-1:0]  sample_ff,    sample_in;
   logic                              active_ff,    active_in;
   logic                              last_ff,      last_in;

   // Working values for the current request.
   logic                              req_take;
   logic [sstg_pkg::PHASE_BITS-1:0]   cur_phase;
   logic [sstg_pkg::INC_BITS-1:0]     cur_inc;
   logic [sstg_pkg::ENV_BITS-1:0]     cur_env;
   logic [sstg_pkg::LENGTH_BITS-1:0]  cur_left;
   logic [sstg_pkg::PHASE_BITS-1:0]   phase_sum;
   logic [31:0]                       level_prod;
   logic [32:0]                       decay_prod;
   logic [sstg_pkg::SAMPLE_BITS-1:0]  mag;

   // A request is taken unless a held result is still stalled.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_inc_ff  <= '0;
         sweep_step_ff <= '0;
         decay_ff      <= sstg_pkg::DECAY_RESET;
         volume_ff     <= sstg_pkg::VOLUME_RESET;
         blip_len_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (sstg_pkg::csr_index_type'(csr_index))
            sstg_pkg::CSR_START_INCREMENT: start_inc_ff  <= csr_data[sstg_pkg::INC_BITS-1:0];
            sstg_pkg::CSR_SWEEP_STEP:      sweep_step_ff <= csr_data[sstg_pkg::SWEEP_BITS-1:0];
            sstg_pkg::CSR_DECAY_FACTOR:    decay_ff      <= csr_data[sstg_pkg::DECAY_BITS-1:0];
            sstg_pkg::CSR_VOLUME:          volume_ff     <= csr_data[sstg_pkg::VOLUME_BITS-1:0];
            sstg_pkg::CSR_BLIP_LENGTH:     blip_len_ff   <= csr_data[sstg_pkg::BLIP_LEN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // A trigger reloads the state before the sample of the same tick is formed.
   always_comb begin
      if (req_trigger) begin
         cur_phase = '0;
         cur_inc   = start_inc_ff;
         cur_env   = sstg_pkg::ENV_ONE;
         cur_left  = sstg_pkg::sat_length(blip_len_ff);
      end else begin
         cur_phase = phase_ff;
         cur_inc   = inc_ff;
         cur_env   = env_ff;
         cur_left  = left_ff;
      end
   end

   // Sample arithmetic: phase advance, envelope times volume, envelope decay.
   always_comb begin
      phase_sum  = cur_phase + sstg_pkg::PHASE_BITS'(cur_inc);
      level_prod = 32'(cur_env) * 32'(volume_ff);
      decay_prod = 33'(cur_env) * 33'(decay_ff);
      if (level_prod[31:16] > sstg_pkg::MAG_MAX) begin
         mag = sstg_pkg::MAG_MAX;
      end else begin
         mag = level_prod[31:16];
      end
   end

   // Next state and next result for an accepted request.
   always_comb begin
      phase_in     = phase_ff;
      inc_in       = inc_ff;
      env_in       = env_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      sample_in    = sample_ff;
      active_in    = active_ff;
      last_in      = last_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
         phase_in     = cur_phase;
         inc_in       = cur_inc;
         env_in       = cur_env;
         left_in      = cur_left;
         sample_in    = '0;
         active_in    = 1'b0;
         last_in      = 1'b0;
         if (cur_left != '0) begin
            phase_in  = phase_sum;
            inc_in    = sstg_pkg::sweep_inc(cur_inc, sweep_step_ff);
            env_in    = decay_prod[32:16];
            left_in   = cur_left - sstg_pkg::LENGTH_BITS'(1);
            active_in = 1'b1;
            last_in   = (cur_left == sstg_pkg::LENGTH_BITS'(1));
            if (phase_sum[sstg_pkg::PHASE_BITS-1]) begin
               sample_in = '0 - mag;
            end else begin
               sample_in = mag;
            end
         end
      end
   end

   // State and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         inc_ff       <= '0;
         env_ff       <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         inc_ff       <= inc_in;
         env_ff       <= env_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      active_ff <= active_in;
      last_ff   <= last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = $signed(sample_ff);
   assign rsp_active = active_ff;
   assign rsp_last   = last_ff;

endmodule

[rtl/sstg_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept square tone generator checker
// Watches the ports of the tone generator and flags results that break its
// rules on sample range, idle output and request flow.
// ----------------------------------------------------------------------------
module sstg_check (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_stall,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic signed [sstg_pkg::SAMPLE_BITS-1:0] rsp_sample,
   input logic                                    rsp_active,
   input logic                                    rsp_last
);

   // The final sample of a blip is always a blip sample.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_active)
      else $error("last flagged on an idle result");

   // An idle result carries silence.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_active |-> rsp_sample == '0)
      else $error("idle result with a non-zero sample");

   // Samples stay within the symmetric range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample != {1'b1, {(sstg_pkg::SAMPLE_BITS-1){1'b0}}})
      else $error("sample outside the symmetric range");

   // Every accepted request yields a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no result");

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_sample) && $stable(rsp_active) && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind swept_square_tone_generator sstg_check u_sstg_check (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_sample (rsp_sample),
   .rsp_active (rsp_active),
   .rsp_last   (rsp_last)
);

[bench/swept_square_tone_generator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept square tone generator testbench
// Feeds sample ticks with and without triggers through the request channel
// and predicts every result in a local copy of the tone state. Registers are
// reprogrammed between phases while the block is idle. Both channels idle in
// random bursts, and the receiver holds off once for a long stretch so that
// the block backs up into its request side.
// ----------------------------------------------------------------------------
module swept_square_tone_generator_test;

   // Indexes past the last register; writes to them must be ignored.
   localparam logic [sstg_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_LOW  = 3'd5;
   localparam logic [sstg_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_HIGH = 3'd7;

   localparam int RANDOM_PHASES    = 5;
   localparam int PHASE_ITEMS      = 100;
   localparam int SETTLE_CYCLES    = 4;
   localparam int LONG_HOLD_AFTER  = 200;
   localparam int LONG_HOLD_CYCLES = 60;
   // The long hold-off is the slowest quiet stretch of a correct run.
   localparam int WATCHDOG_LIMIT   = 1000;

   typedef struct packed {
      logic signed [sstg_pkg::SAMPLE_BITS-1:0] level;
      logic                                    active;
      logic                                    last;
   } tone_sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                    req_valid        = 1'b0;
   logic                                    req_stall;
   logic                                    req_trigger      = 1'b0;
   logic                                    rsp_valid;
   logic                                    rsp_stall        = 1'b0;
   logic signed [sstg_pkg::SAMPLE_BITS-1:0] rsp_sample;
   logic                                    rsp_active;
   logic                                    rsp_last;
   logic                                    csr_write_enable = 1'b0;
   logic [sstg_pkg::CSR_INDEX_BITS-1:0]     csr_index        = '0;
   logic [sstg_pkg::CSR_DATA_BITS-1:0]      csr_data         = '0;

   // Register copies, at their reset values.
   logic [sstg_pkg::INC_BITS-1:0]      cfg_start_inc = '0;
   logic [sstg_pkg::SWEEP_BITS-1:0]    cfg_sweep     = '0;
   logic [sstg_pkg::DECAY_BITS-1:0]    cfg_decay     = sstg_pkg::DECAY_RESET;
   logic [sstg_pkg::VOLUME_BITS-1:0]   cfg_volume    = sstg_pkg::VOLUME_RESET;
   logic [sstg_pkg::BLIP_LEN_BITS-1:0] cfg_length    = '0;

   // Predicted tone state.
   logic [sstg_pkg::PHASE_BITS-1:0]  tone_phase = '0;
   logic [sstg_pkg::INC_BITS-1:0]    tone_inc   = '0;
   logic [sstg_pkg::ENV_BITS-1:0]    tone_env   = '0;
   logic [sstg_pkg::LENGTH_BITS-1:0] tone_left  = '0;

   logic            pending_triggers[$];
   tone_sample_type expected_samples[$];

   logic req_took       = 1'b0;
   logic quiet_tail     = 1'b0;
   logic long_hold_done = 1'b0;
   int   offer_gap      = 0;
   int   hold_left      = 0;
   int   quiet_cycles   = 0;

   int unsigned error_count     = 0;
   int unsigned requests_sent   = 0;
   int unsigned results_seen    = 0;
   int unsigned blip_samples    = 0;
   int unsigned blip_ends       = 0;
   int unsigned register_writes = 0;
   int unsigned settings_count  = 0;

   swept_square_tone_generator u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_trigger      (req_trigger),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_active       (rsp_active),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Only the first ten errors are described; the rest are counted.
   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("ERROR: %s", msg);
      end
   endfunction

   // Mirror a register write, masked to the register width.
   function automatic void store_register(
      input logic [sstg_pkg::CSR_INDEX_BITS-1:0] index,
      input logic [sstg_pkg::CSR_DATA_BITS-1:0]  value
   );
      case (index)
         sstg_pkg::CSR_START_INCREMENT: cfg_start_inc = value[sstg_pkg::INC_BITS-1:0];
         sstg_pkg::CSR_SWEEP_STEP:      cfg_sweep     = value[sstg_pkg::SWEEP_BITS-1:0];
         sstg_pkg::CSR_DECAY_FACTOR:    cfg_decay     = value[sstg_pkg::DECAY_BITS-1:0];
         sstg_pkg::CSR_VOLUME:          cfg_volume    = value[sstg_pkg::VOLUME_BITS-1:0];
         sstg_pkg::CSR_BLIP_LENGTH:     cfg_length    = value[sstg_pkg::BLIP_LEN_BITS-1:0];
         default: ;
      endcase
   endfunction

   // Advance the tone by one tick and return the sample it produces.
   function automatic tone_sample_type step_tone(input logic trigger);
      tone_sample_type                   result;
      logic [31:0]                       gain;
      logic [sstg_pkg::SAMPLE_BITS-1:0]  magnitude;
      logic [32:0]                       decayed;
      logic signed [33:0]                next_inc;
      result = '0;
      // A trigger restarts the blip; counter and register widths match, so
      // the length needs no clamping.
      if (trigger) begin
         tone_phase = '0;
         tone_inc   = cfg_start_inc;
         tone_env   = sstg_pkg::ENV_ONE;
         tone_left  = cfg_length;
      end
      if (tone_left != '0) begin
         tone_phase = tone_phase + sstg_pkg::PHASE_BITS'(tone_inc);
         gain       = 32'(tone_env) * 32'(cfg_volume);
         magnitude  = gain[31:16];
         if (magnitude > sstg_pkg::MAG_MAX) begin
            magnitude = sstg_pkg::MAG_MAX;
         end
         result.level  = tone_phase[sstg_pkg::PHASE_BITS-1] ? -magnitude : magnitude;
         result.active = 1'b1;
         result.last   = (tone_left == sstg_pkg::LENGTH_BITS'(1));
         tone_left     = tone_left - 1'b1;
         // Sweep the phase step, clamped to 0 .. 2^31-1.
         next_inc = $signed({3'b000, tone_inc})
                    + $signed({{2{cfg_sweep[sstg_pkg::SWEEP_BITS-1]}}, cfg_sweep});
         if (next_inc < 0) begin
            tone_inc = '0;
         end else if (next_inc > 34'sh7FFF_FFFF) begin
            tone_inc = '1;
         end else begin
            tone_inc = next_inc[sstg_pkg::INC_BITS-1:0];
         end
         decayed  = 33'(tone_env) * 33'(cfg_decay);
         tone_env = decayed[32:16];
      end
      return result;
   endfunction

   // Mostly extremes, full random words and small values of either sign.
   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return $urandom;
         3: return $urandom >> $urandom_range(0, 31);
         default: return -($urandom >> $urandom_range(8, 31));
      endcase
   endfunction

   // Wait until every request has been answered and the block has settled
   // with nothing left to send.
   task automatic wait_for_idle();
      bit busy;
      busy = 1'b1;
      while (busy) begin
         while (pending_triggers.size() != 0 || req_valid
                || expected_samples.size() != 0) begin
            @(negedge clock);
         end
         repeat (SETTLE_CYCLES) @(negedge clock);
         busy = pending_triggers.size() != 0 || req_valid
                || expected_samples.size() != 0;
      end
   endtask

   task automatic write_register(
      input logic [sstg_pkg::CSR_INDEX_BITS-1:0] index,
      input logic [sstg_pkg::CSR_DATA_BITS-1:0]  value
   );
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= value;
      @(negedge clock);
      store_register(index, value);
      register_writes++;
   endtask

   // Reprogram every register once idle, plus one write to a spare index.
   task automatic program_tone(
      input logic [31:0] start_inc,
      input logic [31:0] sweep,
      input logic [31:0] decay,
      input logic [31:0] volume,
      input logic [31:0] length
   );
      wait_for_idle();
      write_register(sstg_pkg::CSR_START_INCREMENT, start_inc);
      write_register(sstg_pkg::CSR_SWEEP_STEP, sweep);
      write_register(sstg_pkg::CSR_DECAY_FACTOR, decay);
      write_register(sstg_pkg::CSR_VOLUME, volume);
      write_register(sstg_pkg::CSR_BLIP_LENGTH, length);
      write_register(sstg_pkg::CSR_INDEX_BITS'($urandom_range(CSR_SPARE_LOW, CSR_SPARE_HIGH)),
                     $urandom);
      csr_write_enable <= 1'b0;
      settings_count++;
   endtask

   // Request driver: holds a stalled request, otherwise offers the next one.
   always @(negedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_trigger <= 1'b0;
         offer_gap = 0;
      end else if (!req_valid || req_took) begin
         if (offer_gap != 0) begin
            offer_gap = offer_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_triggers.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            offer_gap = $urandom_range(0, 17);
            req_valid <= 1'b0;
         end else begin
            req_valid   <= 1'b1;
            req_trigger <= pending_triggers.pop_front();
         end
      end
   end

   // Result receiver: random stall bursts and one long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
         hold_left = $urandom_range(0, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check results against the oldest prediction, then predict new requests.
   always @(posedge clock) begin : check_results
      tone_sample_type want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_active) begin
               blip_samples++;
            end
            if (rsp_last) begin
               blip_ends++;
            end
            if (expected_samples.size() == 0) begin
               note_error($sformatf("result %0d with none expected: level %0d active %0b last %0b",
                                    results_seen, rsp_sample, rsp_active, rsp_last));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample !== want.level || rsp_active !== want.active
                   || rsp_last !== want.last) begin
                  note_error($sformatf({"result %0d: expected level %0d active %0b last %0b,",
                                        " got level %0d active %0b last %0b"},
                                       results_seen, want.level, want.active, want.last,
                                       rsp_sample, rsp_active, rsp_last));
               end
            end
         end
         if (req_valid && !req_stall) begin
            requests_sent++;
            expected_samples.push_back(step_tone(req_trigger));
         end
      end
   end

   // Watchdog on cycles in which neither channel moves.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int          phase;
      int          count;
      int          span;
      int          reach;
      logic [31:0] length_word;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Reset values: an idle tick, then a trigger with zero length stays idle.
      pending_triggers.push_back(1'b0);
      pending_triggers.push_back(1'b1);

      // Largest start step with an upward sweep that saturates at once.
      program_tone(32'h7FFF_FFFF, 32'd1, 32'h0000_FFFF, 32'h0000_7FFF, 32'd5);
      pending_triggers.push_back(1'b1);
      repeat (5) pending_triggers.push_back(1'b0);

      // Most negative sweep, silent gain and single-sample blips retriggered.
      program_tone(32'h0000_0100, 32'h8000_0000, 32'd0, 32'd0, 32'd1);
      pending_triggers.push_back(1'b1);
      pending_triggers.push_back(1'b0);
      pending_triggers.push_back(1'b1);
      pending_triggers.push_back(1'b1);

      // Longest blip, cut short by a trigger in the middle.
      program_tone(32'h4000_0000, 32'hFFFF_FFFF, 32'h0000_8000, 32'd12345, 32'h0000_FFFF);
      pending_triggers.push_back(1'b1);
      pending_triggers.push_back(1'b0);
      pending_triggers.push_back(1'b0);
      pending_triggers.push_back(1'b1);
      pending_triggers.push_back(1'b0);

      // Upper bits beyond the narrow registers are dropped. The long blip
      // runs on with the new sweep, decay and gain; start step and length
      // wait for the next trigger.
      program_tone(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'hFFFF_0003);
      repeat (3) pending_triggers.push_back(1'b0);
      pending_triggers.push_back(1'b1);
      repeat (4) pending_triggers.push_back(1'b0);

      // Random phases of blips with random content; the last one runs flat out.
      for (phase = 0; phase <= RANDOM_PHASES; phase++) begin
         if ($urandom_range(0, 7) == 0) begin
            length_word = $urandom;
         end else if ($urandom_range(0, 7) == 0) begin
            length_word = '0;
         end else begin
            length_word = $urandom_range(1, 24);
         end
         program_tone(random_word(), random_word(), random_word(), random_word(), length_word);
         if (phase == RANDOM_PHASES) begin
            quiet_tail = 1'b1;
         end
         reach = (cfg_length > 40) ? 40 : int'(cfg_length);
         count = 0;
         while (count < PHASE_ITEMS) begin
            // Mostly a trigger followed by about a blip of plain ticks.
            pending_triggers.push_back($urandom_range(0, 7) != 0);
            count++;
            span = $urandom_range(0, reach + 3);
            while (span > 0 && count < PHASE_ITEMS) begin
               pending_triggers.push_back(1'b0);
               count++;
               span--;
            end
         end
      end

      wait_for_idle();
      if (expected_samples.size() != 0) begin
         note_error($sformatf("%0d results never arrived", expected_samples.size()));
      end
      $display("Covered %0d requests and %0d checked results, %0d blip samples, %0d blip ends.",
               requests_sent, results_seen, blip_samples, blip_ends);
      $display("Made %0d register writes over %0d settings, with a long receiver hold-off.",
               register_writes, settings_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/sstg_pkg.sv
rtl/swept_square_tone_generator.sv
rtl/sstg_check.sv
bench/swept_square_tone_generator_test.sv
